// ----- hw/rtl/gcmpt_pkg.sv -----
// gcmpt_pkg: shared types, constants and helper functions for the gpio channel map
// and press tracker. No dependencies; used by every rtl file of the block.
`timescale 1ns / 1ps

package gcmpt_pkg;

    // port and timestamp geometry
    localparam int PORT_PINS = 16;
    localparam int PORT_W    = 16;
    localparam int TIME_W    = 32;
    localparam int CHANNELS  = 16;
    localparam int CH_W      = 4;
    localparam int COUNT_W   = 5;
    localparam int MAP_W     = CHANNELS * CH_W;
    localparam int DUR_W     = 32;

    localparam logic [PORT_W-1:0] PORT_MASK =
        PORT_W'((64'd1 << PORT_PINS) - 64'd1) & 16'hFFFF;

    // stream payload widths
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 88;

    // configuration port
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;

    // queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    // register indexes
    localparam logic [1:0] REG_IN_MAP    = 2'd0;
    localparam logic [1:0] REG_IN_COUNT  = 2'd1;
    localparam logic [1:0] REG_OUT_MAP   = 2'd2;
    localparam logic [1:0] REG_OUT_COUNT = 2'd3;

    typedef enum logic [2:0] {
        CMD_SAMPLE    = 3'd0,
        CMD_WRITE_ALL = 3'd1,
        CMD_WRITE_CH  = 3'd2,
        CMD_TOGGLE_CH = 3'd3,
        CMD_QUERY_CH  = 3'd4,
        CMD_NOP       = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        PRESS_NONE     = 2'd0,
        PRESS_HELD     = 2'd1,
        PRESS_RELEASED = 2'd2
    } t_press;

    // one decoded transaction waiting in the queue
    typedef struct packed {
        t_cmd              cmd;
        logic [PORT_W-1:0] pins;
        logic [TIME_W-1:0] now;
        logic [PORT_W-1:0] wdata;
        logic [CH_W-1:0]   ch;
        logic              level;
    } t_item;

    // configuration seen by the back end
    typedef struct packed {
        logic [MAP_W-1:0]   in_map;
        logic [COUNT_W-1:0] in_count;
        logic [MAP_W-1:0]   out_map;
        logic [COUNT_W-1:0] out_count;
        logic [PORT_W-1:0]  omask;
    } t_cfg;

    // latch update caused by an output map or count write
    typedef struct packed {
        logic              en;
        logic [PORT_W-1:0] mask;
    } t_remask;

    // pin index of logical channel ch
    function automatic logic [CH_W-1:0] pin_of(logic [MAP_W-1:0] map, logic [CH_W-1:0] ch);
        return map[ch*CH_W +: CH_W];
    endfunction

    // set of pins used by the first count channels of a map
    function automatic logic [PORT_W-1:0] map_mask(logic [MAP_W-1:0] map,
                                                   logic [COUNT_W-1:0] count);
        logic [PORT_W-1:0] m;
        m = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (COUNT_W'(i) < count) begin
                m[pin_of(map, CH_W'(i))] = 1'b1;
            end
        end
        return m;
    endfunction

    // saturate a written count at the channel total
    function automatic logic [COUNT_W-1:0] sat_count(logic [CFG_DATA_W-1:0] value);
        logic [COUNT_W-1:0] c;
        c = value[COUNT_W-1:0];
        return (c > COUNT_W'(CHANNELS)) ? COUNT_W'(CHANNELS) : c;
    endfunction

endpackage

// ----- hw/rtl/gcmpt_front.sv -----
// gcmpt_front: accepts stream transactions, decodes the command and queues them.
// Depends on gcmpt_pkg.
`timescale 1ns / 1ps

module gcmpt_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // command[2:0] pin_levels[18:3] now_ticks[50:19] write_data[66:51] channel[70:67]
    // level[71]
    input  logic [gcmpt_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                               o_head_valid,
    output gcmpt_pkg::t_item                   o_head,
    input  logic                               i_pop
);

    gcmpt_pkg::t_item                r_mem [gcmpt_pkg::QDEPTH];
    logic [gcmpt_pkg::QPTR_W-1:0]    r_wptr, n_wptr;
    logic [gcmpt_pkg::QPTR_W-1:0]    r_rptr, n_rptr;
    logic [gcmpt_pkg::QCNT_W-1:0]    r_count, n_count;
    gcmpt_pkg::t_item                dec;
    logic                            push;
    logic                            pop;

    // command decode, unknown codes become no-ops
    always_comb begin
        dec.pins  = i_s_tdata[18:3];
        dec.now   = i_s_tdata[50:19];
        dec.wdata = i_s_tdata[66:51];
        dec.ch    = i_s_tdata[70:67];
        dec.level = i_s_tdata[71];
        unique case (i_s_tdata[2:0]) inside
            gcmpt_pkg::CMD_SAMPLE, gcmpt_pkg::CMD_WRITE_ALL, gcmpt_pkg::CMD_WRITE_CH,
            gcmpt_pkg::CMD_TOGGLE_CH, gcmpt_pkg::CMD_QUERY_CH: begin
                dec.cmd = gcmpt_pkg::t_cmd'(i_s_tdata[2:0]);
            end
            default: begin
                dec.cmd = gcmpt_pkg::CMD_NOP;
            end
        endcase
    end

    // queue handshake
    assign o_s_tready   = (r_count != gcmpt_pkg::QCNT_W'(gcmpt_pkg::QDEPTH));
    assign push         = i_s_tvalid && o_s_tready;
    assign o_head_valid = (r_count != '0);
    assign pop          = i_pop && o_head_valid;
    assign o_head       = r_mem[r_rptr];

    // pointer and fill count update
    always_comb begin
        n_wptr  = push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= dec;
        end
    end

endmodule

// ----- hw/rtl/gcmpt_back.sv -----
// gcmpt_back: executes queued commands against the latch and press state and
// holds the result in an output register. Depends on gcmpt_pkg.
`timescale 1ns / 1ps

module gcmpt_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_head_valid,
    input  gcmpt_pkg::t_item                   i_head,
    output logic                               o_pop,
    input  gcmpt_pkg::t_cfg                    i_cfg,
    input  gcmpt_pkg::t_remask                 i_remask,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // pin_drive[15:0] direction_word[31:16] packed_inputs[47:32] changed[48]
    // chan_state[50:49] chan_duration[82:51] chan_level[83] channel_error[84] zero[87:85]
    output logic [gcmpt_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    logic [gcmpt_pkg::PORT_W-1:0]  r_latch, n_latch;
    logic [gcmpt_pkg::PORT_W-1:0]  r_last, n_last;
    gcmpt_pkg::t_press             r_state [gcmpt_pkg::CHANNELS];
    gcmpt_pkg::t_press             n_state [gcmpt_pkg::CHANNELS];
    logic [gcmpt_pkg::TIME_W-1:0]  r_start [gcmpt_pkg::CHANNELS];
    logic [gcmpt_pkg::TIME_W-1:0]  n_start [gcmpt_pkg::CHANNELS];
    logic [gcmpt_pkg::TIME_W-1:0]  r_dur   [gcmpt_pkg::CHANNELS];
    logic [gcmpt_pkg::TIME_W-1:0]  n_dur   [gcmpt_pkg::CHANNELS];
    logic                          r_out_valid;
    logic [gcmpt_pkg::OUT_TDATA_W-1:0] r_out, n_out;
    logic                          take;

    // result fields
    logic [gcmpt_pkg::PORT_W-1:0]  imask;
    logic [gcmpt_pkg::PORT_W-1:0]  word;
    logic [gcmpt_pkg::PORT_W-1:0]  seen_in;
    logic [gcmpt_pkg::PORT_W-1:0]  packed_in;
    logic [gcmpt_pkg::PORT_W-1:0]  drive;
    logic                          changed;
    gcmpt_pkg::t_press             st;
    logic [gcmpt_pkg::DUR_W-1:0]   dur;
    logic                          lev;
    logic                          err;
    logic [gcmpt_pkg::CH_W-1:0]    pin;
    logic [gcmpt_pkg::COUNT_W-1:0] slot;
    logic                          bit_a, bit_b;

    // pop when the output register is free or drains this cycle
    assign take  = i_head_valid && (!r_out_valid || i_m_tready);
    assign o_pop = take;

    // command execution and result assembly
    always_comb begin
        n_latch = r_latch;
        n_last  = r_last;
        n_state = r_state;
        n_start = r_start;
        n_dur   = r_dur;
        imask   = ~i_cfg.omask;
        word    = '0;
        changed = 1'b0;
        st      = gcmpt_pkg::PRESS_NONE;
        dur     = '0;
        lev     = 1'b0;
        err     = 1'b0;
        pin     = '0;
        bit_a   = 1'b0;
        bit_b   = 1'b0;
        if (take) begin
            unique case (i_head.cmd) inside
                gcmpt_pkg::CMD_SAMPLE: begin
                    word = i_head.pins | i_cfg.omask | ~gcmpt_pkg::PORT_MASK;
                    if (word != r_last) begin
                        // edge logic per input channel lane
                        for (int i = 0; i < gcmpt_pkg::CHANNELS; i++) begin
                            if (gcmpt_pkg::COUNT_W'(i) < i_cfg.in_count) begin
                                pin   = gcmpt_pkg::pin_of(i_cfg.in_map, gcmpt_pkg::CH_W'(i));
                                bit_a = r_last[pin];
                                bit_b = word[pin];
                                if (bit_a && !bit_b) begin
                                    n_start[i] = i_head.now;
                                    n_state[i] = gcmpt_pkg::PRESS_HELD;
                                    n_dur[i]   = '0;
                                end else if (!bit_a && bit_b) begin
                                    n_state[i] = gcmpt_pkg::PRESS_RELEASED;
                                    n_dur[i]   = i_head.now - r_start[i];
                                end else if (bit_a && bit_b) begin
                                    n_state[i] = gcmpt_pkg::PRESS_NONE;
                                end
                            end
                        end
                        n_last  = word;
                        changed = 1'b1;
                    end
                end
                gcmpt_pkg::CMD_WRITE_ALL: begin
                    // later channels win on a shared pin
                    for (int i = 0; i < gcmpt_pkg::CHANNELS; i++) begin
                        if (gcmpt_pkg::COUNT_W'(i) < i_cfg.out_count) begin
                            n_latch[gcmpt_pkg::pin_of(i_cfg.out_map, gcmpt_pkg::CH_W'(i))] =
                                i_head.wdata[i];
                        end
                    end
                end
                gcmpt_pkg::CMD_WRITE_CH, gcmpt_pkg::CMD_TOGGLE_CH: begin
                    if ({1'b0, i_head.ch} >= i_cfg.out_count) begin
                        err = 1'b1;
                    end else begin
                        pin = gcmpt_pkg::pin_of(i_cfg.out_map, i_head.ch);
                        lev = (i_head.cmd == gcmpt_pkg::CMD_WRITE_CH) ?
                              i_head.level : ~r_latch[pin];
                        n_latch[pin] = lev;
                    end
                end
                gcmpt_pkg::CMD_QUERY_CH: begin
                    if ({1'b0, i_head.ch} < i_cfg.out_count) begin
                        lev = r_latch[gcmpt_pkg::pin_of(i_cfg.out_map, i_head.ch)];
                    end
                    if ({1'b0, i_head.ch} >= i_cfg.in_count) begin
                        err = 1'b1;
                    end else begin
                        st  = r_state[i_head.ch];
                        dur = gcmpt_pkg::DUR_W'(r_dur[i_head.ch]);
                    end
                end
                default: begin
                end
            endcase
        end
        // output map or count write drives the latch bit of every mapped output pin high
        if (i_remask.en) begin
            n_latch = n_latch | i_remask.mask;
        end
    end

    // gather input channels, channel 0 in the highest used bit
    always_comb begin
        seen_in   = n_last & imask;
        packed_in = '0;
        slot      = '0;
        for (int i = 0; i < gcmpt_pkg::CHANNELS; i++) begin
            if (gcmpt_pkg::COUNT_W'(i) < i_cfg.in_count) begin
                slot = i_cfg.in_count - gcmpt_pkg::COUNT_W'(i + 1);
                packed_in[slot[gcmpt_pkg::CH_W-1:0]] =
                    seen_in[gcmpt_pkg::pin_of(i_cfg.in_map, gcmpt_pkg::CH_W'(i))];
            end
        end
        drive = (n_latch | imask) & gcmpt_pkg::PORT_MASK;
        n_out = {3'b000, err, lev, dur, st, changed, packed_in, imask, drive};
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch <= '0;
            r_last  <= '1;
            for (int i = 0; i < gcmpt_pkg::CHANNELS; i++) begin
                r_state[i] <= gcmpt_pkg::PRESS_NONE;
                r_start[i] <= '0;
                r_dur[i]   <= '0;
            end
        end else begin
            r_latch <= n_latch;
            r_last  <= n_last;
            r_state <= n_state;
            r_start <= n_start;
            r_dur   <= n_dur;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

endmodule

// ----- hw/rtl/gpio_channel_map_press_tracker_top.sv -----
// gpio_channel_map_press_tracker_top: configuration registers and the front, queue
// and back of the block. Depends on gcmpt_pkg, gcmpt_front and gcmpt_back.
`timescale 1ns / 1ps

// Usage
// The slave stream takes one command transaction per cycle while o_s_tready is high:
// sample, write all, write channel, toggle channel or query channel. Every command gives
// exactly one result transaction on the master stream, in order.
// The APB port holds four 64-bit registers at byte addresses 0, 8, 16 and 24:
// input pin map, input count, output pin map, output count. Writes take effect at
// the access cycle; a write of the output map or count drives the latch bit of
// every mapped output pin high. Write configuration only while no result is open.
// A command waits in the two-entry command queue, then the execute stage loads the
// output register with its result.
// Throughput is one transaction per cycle while the receiver takes results, set by the
// single execute stage that updates all sixteen press lanes in parallel.
// When the receiver stalls the result waits in the output register, the queue fills
// with up to two commands, and then o_s_tready drops until the result is taken.
// Reset (synchronous, active low) clears the queue, the output register, the latch,
// all press state and all registers; the last port word resets to all ones.

module gpio_channel_map_press_tracker_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // command[2:0] pin_levels[18:3] now_ticks[50:19] write_data[66:51] channel[70:67]
    // level[71]
    input  logic [gcmpt_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // pin_drive[15:0] direction_word[31:16] packed_inputs[47:32] changed[48]
    // chan_state[50:49] chan_duration[82:51] chan_level[83] channel_error[84] zero[87:85]
    output logic [gcmpt_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gcmpt_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [gcmpt_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [gcmpt_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                pready
);

    logic [gcmpt_pkg::MAP_W-1:0]   r_in_map, n_in_map;
    logic [gcmpt_pkg::COUNT_W-1:0] r_in_count, n_in_count;
    logic [gcmpt_pkg::MAP_W-1:0]   r_out_map, n_out_map;
    logic [gcmpt_pkg::COUNT_W-1:0] r_out_count, n_out_count;
    logic [gcmpt_pkg::PORT_W-1:0]  r_omask, n_omask;
    logic                          wr_en;
    logic                          out_wr;
    logic [1:0]                    reg_idx;
    gcmpt_pkg::t_cfg               cfg;
    gcmpt_pkg::t_remask            remask;
    gcmpt_pkg::t_item              head;
    logic                          head_valid;
    logic                          pop;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:3];

    // register write decode
    always_comb begin
        n_in_map    = r_in_map;
        n_in_count  = r_in_count;
        n_out_map   = r_out_map;
        n_out_count = r_out_count;
        out_wr      = 1'b0;
        if (wr_en) begin
            unique case (reg_idx)
                gcmpt_pkg::REG_IN_MAP:   n_in_map   = pwdata;
                gcmpt_pkg::REG_IN_COUNT: n_in_count = gcmpt_pkg::sat_count(pwdata);
                gcmpt_pkg::REG_OUT_MAP: begin
                    n_out_map = pwdata;
                    out_wr    = 1'b1;
                end
                gcmpt_pkg::REG_OUT_COUNT: begin
                    n_out_count = gcmpt_pkg::sat_count(pwdata);
                    out_wr      = 1'b1;
                end
                default: begin
                end
            endcase
        end
        n_omask = out_wr ? gcmpt_pkg::map_mask(n_out_map, n_out_count) : r_omask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_map    <= '0;
            r_in_count  <= '0;
            r_out_map   <= '0;
            r_out_count <= '0;
            r_omask     <= '0;
        end else begin
            r_in_map    <= n_in_map;
            r_in_count  <= n_in_count;
            r_out_map   <= n_out_map;
            r_out_count <= n_out_count;
            r_omask     <= n_omask;
        end
    end

    // register read back
    always_comb begin
        unique case (reg_idx)
            gcmpt_pkg::REG_IN_MAP:    prdata = r_in_map;
            gcmpt_pkg::REG_IN_COUNT:  prdata = gcmpt_pkg::CFG_DATA_W'(r_in_count);
            gcmpt_pkg::REG_OUT_MAP:   prdata = r_out_map;
            gcmpt_pkg::REG_OUT_COUNT: prdata = gcmpt_pkg::CFG_DATA_W'(r_out_count);
            default:                  prdata = '0;
        endcase
    end

    assign cfg.in_map    = r_in_map;
    assign cfg.in_count  = r_in_count;
    assign cfg.out_map   = r_out_map;
    assign cfg.out_count = r_out_count;
    assign cfg.omask     = r_omask;
    assign remask.en     = out_wr;
    assign remask.mask   = n_omask;

    gcmpt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    gcmpt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .i_cfg        (cfg),
        .i_remask     (remask),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata)
    );

endmodule

// ----- hw/rtl/gcmpt_checker.sv -----
// gcmpt_checker: port-level assertions for the press tracker top level, bound in.
// Depends on gcmpt_pkg and gpio_channel_map_press_tracker_top.
`timescale 1ns / 1ps

module gcmpt_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [gcmpt_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    // no result straight out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // every input pin is driven high
    a_drive_covers_inputs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata[15:0] & o_m_tdata[31:16]) == o_m_tdata[31:16]))
        else $error("input pin not driven high");

    // a channel error carries no press status
    a_error_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[84]) |-> (o_m_tdata[50:49] == 2'd0 &&
                                           o_m_tdata[82:51] == '0))
        else $error("press status given with channel error");

    // a press state is never the unused code
    a_state_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[50:49] != 2'd3))
        else $error("unused press state code");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind gpio_channel_map_press_tracker_top gcmpt_checker u_gcmpt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ----- dv/tb_gpio_channel_map_press_tracker_top.sv -----
// tb_gpio_channel_map_press_tracker_top: self-checking bench for the channel map and press
// tracker; drives command and apb traffic and predicts every status transaction.
// Depends on gcmpt_pkg and gpio_channel_map_press_tracker_top.
`timescale 1ns / 1ps

module tb_gpio_channel_map_press_tracker_top;

    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 8;
    localparam int HOLD_OFF    = 80;

    // command codes the block treats as no-ops
    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;

    // command transaction, first field in the lowest bits
    typedef struct packed {
        logic                         level;
        logic [gcmpt_pkg::CH_W-1:0]   ch;
        logic [gcmpt_pkg::PORT_W-1:0] wdata;
        logic [gcmpt_pkg::TIME_W-1:0] now;
        logic [gcmpt_pkg::PORT_W-1:0] pins;
        logic [2:0]                   cmd;
    } t_cmd_item;

    // status transaction, first field in the lowest bits
    typedef struct packed {
        logic [2:0]                   pad;
        logic                         err;
        logic                         lev;
        logic [gcmpt_pkg::DUR_W-1:0]  dur;
        logic [1:0]                   st;
        logic                         changed;
        logic [gcmpt_pkg::PORT_W-1:0] packed_in;
        logic [gcmpt_pkg::PORT_W-1:0] dir;
        logic [gcmpt_pkg::PORT_W-1:0] drive;
    } t_status;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_s_tvalid = 1'b0;
    logic                              o_s_tready;
    logic [gcmpt_pkg::IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                              o_m_tvalid;
    logic                              i_m_tready = 1'b0;
    logic [gcmpt_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [gcmpt_pkg::CFG_ADDR_W-1:0]  paddr = '0;
    logic [gcmpt_pkg::CFG_DATA_W-1:0]  pwdata = '0;
    logic [gcmpt_pkg::CFG_DATA_W-1:0]  prdata;
    logic                              pready;

    gpio_channel_map_press_tracker_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #1 i_clk = ~i_clk;

    // shadow of the block's registers and press state
    logic [gcmpt_pkg::MAP_W-1:0]  sh_in_map;
    logic [gcmpt_pkg::MAP_W-1:0]  sh_out_map;
    int unsigned                  sh_in_count;
    int unsigned                  sh_out_count;
    logic [gcmpt_pkg::PORT_W-1:0] latch_bits;
    logic [gcmpt_pkg::PORT_W-1:0] port_word;
    gcmpt_pkg::t_press            press_phase [gcmpt_pkg::CHANNELS];
    logic [gcmpt_pkg::TIME_W-1:0] press_t0 [gcmpt_pkg::CHANNELS];
    logic [gcmpt_pkg::DUR_W-1:0]  press_len [gcmpt_pkg::CHANNELS];

    t_status pending_status [$];
    t_status seen_status;
    t_status due_status;

    int unsigned items_sent = 0;
    int unsigned statuses_checked = 0;
    int unsigned status_mismatches = 0;
    int unsigned reg_writes = 0;
    int unsigned quiet_cycles = 0;
    int unsigned sink_hold_req = 0;
    bit          src_idle_en = 1'b1;
    bit          sink_idle_en = 1'b1;
    logic [gcmpt_pkg::TIME_W-1:0] tick_now;
    logic [gcmpt_pkg::PORT_W-1:0] pin_pattern;

    function automatic logic [gcmpt_pkg::CH_W-1:0] pin_at(logic [gcmpt_pkg::MAP_W-1:0] map,
                                                          int unsigned ch);
        return gcmpt_pkg::CH_W'((map >> (4 * ch)) & 64'hF);
    endfunction

    // port pins taken by the output channels in use
    function automatic logic [gcmpt_pkg::PORT_W-1:0] output_pins();
        logic [gcmpt_pkg::PORT_W-1:0] m;
        int unsigned i;
        m = '0;
        for (i = 0; i < sh_out_count; i++) m[pin_at(sh_out_map, i)] = 1'b1;
        return m;
    endfunction

    function automatic void shadow_reset();
        int unsigned i;
        sh_in_map = '0;
        sh_out_map = '0;
        sh_in_count = 0;
        sh_out_count = 0;
        latch_bits = '0;
        port_word = '1;
        for (i = 0; i < gcmpt_pkg::CHANNELS; i++) begin
            press_phase[i] = gcmpt_pkg::PRESS_NONE;
            press_t0[i] = '0;
            press_len[i] = '0;
        end
    endfunction

    // register write as seen by the shadow; counts saturate at sixteen
    function automatic void shadow_reg_write(logic [1:0] idx, logic [63:0] value);
        int unsigned c;
        c = value[4:0];
        if (c > gcmpt_pkg::CHANNELS) c = gcmpt_pkg::CHANNELS;
        case (idx)
            gcmpt_pkg::REG_IN_MAP:   sh_in_map = value;
            gcmpt_pkg::REG_IN_COUNT: sh_in_count = c;
            gcmpt_pkg::REG_OUT_MAP:  sh_out_map = value;
            default:                 sh_out_count = c;
        endcase
        if (idx == gcmpt_pkg::REG_OUT_MAP || idx == gcmpt_pkg::REG_OUT_COUNT)
            latch_bits |= output_pins();
    endfunction

    // expected status of one command, updating the shadow state
    function automatic t_status apply_command(t_cmd_item it);
        t_status r;
        logic [gcmpt_pkg::PORT_W-1:0] omask;
        logic [gcmpt_pkg::PORT_W-1:0] imask;
        logic [gcmpt_pkg::PORT_W-1:0] w;
        logic [gcmpt_pkg::CH_W-1:0] p;
        logic a;
        logic b;
        int unsigned i;
        omask = output_pins();
        imask = ~omask;
        r = '0;
        case (it.cmd)
            gcmpt_pkg::CMD_SAMPLE: begin
                w = it.pins | omask;
                if (w != port_word) begin
                    for (i = 0; i < sh_in_count; i++) begin
                        p = pin_at(sh_in_map, i);
                        a = port_word[p];
                        b = w[p];
                        if (a && !b) begin
                            press_phase[i] = gcmpt_pkg::PRESS_HELD;
                            press_t0[i] = it.now;
                            press_len[i] = '0;
                        end else if (!a && b) begin
                            press_phase[i] = gcmpt_pkg::PRESS_RELEASED;
                            press_len[i] = it.now - press_t0[i];
                        end else if (a && b) begin
                            press_phase[i] = gcmpt_pkg::PRESS_NONE;
                        end
                    end
                    port_word = w;
                    r.changed = 1'b1;
                end
            end
            gcmpt_pkg::CMD_WRITE_ALL: begin
                for (i = 0; i < sh_out_count; i++)
                    latch_bits[pin_at(sh_out_map, i)] = it.wdata[i];
            end
            gcmpt_pkg::CMD_WRITE_CH, gcmpt_pkg::CMD_TOGGLE_CH: begin
                if (it.ch >= sh_out_count) begin
                    r.err = 1'b1;
                end else begin
                    p = pin_at(sh_out_map, it.ch);
                    latch_bits[p] = (it.cmd == gcmpt_pkg::CMD_WRITE_CH) ?
                                    it.level : ~latch_bits[p];
                    r.lev = latch_bits[p];
                end
            end
            gcmpt_pkg::CMD_QUERY_CH: begin
                if (it.ch < sh_out_count) r.lev = latch_bits[pin_at(sh_out_map, it.ch)];
                if (it.ch >= sh_in_count) begin
                    r.err = 1'b1;
                end else begin
                    r.st = press_phase[it.ch];
                    r.dur = press_len[it.ch];
                end
            end
            default: ;
        endcase
        // channel 0 ends up in the highest used bit
        for (i = 0; i < sh_in_count; i++) begin
            p = pin_at(sh_in_map, i);
            r.packed_in = {r.packed_in[gcmpt_pkg::PORT_W-2:0], port_word[p] & imask[p]};
        end
        r.drive = latch_bits | imask;
        r.dir = imask;
        return r;
    endfunction

    function automatic t_cmd_item make_cmd(logic [2:0] cmd,
                                           logic [gcmpt_pkg::PORT_W-1:0] pins,
                                           logic [gcmpt_pkg::TIME_W-1:0] now,
                                           logic [gcmpt_pkg::PORT_W-1:0] wdata,
                                           logic [gcmpt_pkg::CH_W-1:0] ch, logic level);
        t_cmd_item it;
        it.cmd = cmd;
        it.pins = pins;
        it.now = now;
        it.wdata = wdata;
        it.ch = ch;
        it.level = level;
        return it;
    endfunction

    // random command; samples mostly flip a few pins of the last word, time mostly moves forward
    function automatic t_cmd_item random_command();
        t_cmd_item it;
        int unsigned roll;
        int unsigned lim;
        roll = $urandom_range(99);
        it.level = 1'($urandom_range(1));
        it.wdata = gcmpt_pkg::PORT_W'($urandom);
        it.pins = gcmpt_pkg::PORT_W'($urandom);
        if (roll < 40) it.cmd = gcmpt_pkg::CMD_SAMPLE;
        else if (roll < 50) it.cmd = gcmpt_pkg::CMD_WRITE_ALL;
        else if (roll < 63) it.cmd = gcmpt_pkg::CMD_WRITE_CH;
        else if (roll < 74) it.cmd = gcmpt_pkg::CMD_TOGGLE_CH;
        else if (roll < 95) it.cmd = gcmpt_pkg::CMD_QUERY_CH;
        else it.cmd = 3'($urandom_range(CMD_RSVD_7, gcmpt_pkg::CMD_NOP));
        lim = (it.cmd == gcmpt_pkg::CMD_QUERY_CH) ? sh_in_count : sh_out_count;
        if (lim > 0 && $urandom_range(9) < 7)
            it.ch = gcmpt_pkg::CH_W'($urandom_range(lim - 1));
        else
            it.ch = gcmpt_pkg::CH_W'($urandom_range(15));
        if ($urandom_range(19) == 0) tick_now = $urandom;
        else tick_now += gcmpt_pkg::TIME_W'($urandom_range(300));
        it.now = tick_now;
        if (it.cmd == gcmpt_pkg::CMD_SAMPLE) begin
            if ($urandom_range(9) != 0) begin
                pin_pattern ^= gcmpt_pkg::PORT_W'(1 << $urandom_range(15));
                if ($urandom_range(3) == 0)
                    pin_pattern ^= gcmpt_pkg::PORT_W'(1 << $urandom_range(15));
                it.pins = pin_pattern;
            end else begin
                pin_pattern = it.pins;
            end
        end
        return it;
    endfunction

    // offer one command and wait for the handshake
    task automatic send_command(t_cmd_item it);
        if (src_idle_en && $urandom_range(99) < 6) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= it;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_status.push_back(apply_command(it));
        items_sent++;
    endtask

    // stop offering and wait for every open status
    task automatic drain_status();
        i_s_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shadow_reg_write(idx, value);
        reg_writes++;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(logic [63:0] in_map, logic [63:0] in_cnt,
                                 logic [63:0] out_map, logic [63:0] out_cnt);
        drain_status();
        write_reg(gcmpt_pkg::REG_IN_MAP, in_map);
        write_reg(gcmpt_pkg::REG_IN_COUNT, in_cnt);
        write_reg(gcmpt_pkg::REG_OUT_MAP, out_map);
        write_reg(gcmpt_pkg::REG_OUT_COUNT, out_cnt);
    endtask

    // reset values: no channels in use, every pin an input
    task automatic test_reset_defaults();
        send_command(make_cmd(gcmpt_pkg::CMD_SAMPLE, 16'h0000, 32'd0, 16'h0000, 4'd0, 1'b0));
        send_command(make_cmd(gcmpt_pkg::CMD_QUERY_CH, 16'h0000, 32'd1, 16'h0000, 4'd0, 1'b0));
        send_command(make_cmd(gcmpt_pkg::CMD_WRITE_CH, 16'h0000, 32'd2, 16'h0000, 4'd0, 1'b1));
        send_command(make_cmd(gcmpt_pkg::CMD_NOP, 16'hFFFF, 32'd3, 16'hFFFF, 4'd15, 1'b1));
        send_command(make_cmd(CMD_RSVD_7, 16'h0000, 32'd4, 16'h0000, 4'd0, 1'b0));
    endtask

    // identity input map, four outputs on the top pins, saturated input count
    task automatic test_directed_mapping();
        apply_setting(64'hFEDC_BA98_7654_3210, 64'd31, 64'h0000_0000_0000_FEDC, 64'd4);
        // an all-high sample that changes nothing, then presses, a repeat and releases with a wrapped duration
        send_command(make_cmd(gcmpt_pkg::CMD_SAMPLE, 16'hFFFF, 32'd100, 16'h0000, 4'd0, 1'b0));
        send_command(make_cmd(gcmpt_pkg::CMD_SAMPLE, 16'h0000, 32'hFFFF_FFF0, 16'h0000, 4'd0,
                              1'b0));
        send_command(make_cmd(gcmpt_pkg::CMD_SAMPLE, 16'h0000, 32'd5, 16'h0000, 4'd0, 1'b0));
        send_command(make_cmd(gcmpt_pkg::CMD_SAMPLE, 16'h0F0F, 32'h0000_0010, 16'h0000, 4'd0,
                              1'b0));
        send_command(make_cmd(gcmpt_pkg::CMD_QUERY_CH, 16'h0000, 32'd0, 16'h0000, 4'd0, 1'b0));
        send_command(make_cmd(gcmpt_pkg::CMD_QUERY_CH, 16'h0000, 32'd0, 16'h0000, 4'd4, 1'b0));
        send_command(make_cmd(gcmpt_pkg::CMD_QUERY_CH, 16'h0000, 32'd0, 16'h0000, 4'd15, 1'b0));
        // latch writes, toggles and out of range channels
        send_command(make_cmd(gcmpt_pkg::CMD_WRITE_ALL, 16'h0000, 32'd0, 16'h0000, 4'd0, 1'b0));
        send_command(make_cmd(gcmpt_pkg::CMD_WRITE_ALL, 16'h0000, 32'd0, 16'hFFFF, 4'd0, 1'b0));
        send_command(make_cmd(gcmpt_pkg::CMD_WRITE_CH, 16'h0000, 32'd0, 16'h0000, 4'd1, 1'b0));
        send_command(make_cmd(gcmpt_pkg::CMD_TOGGLE_CH, 16'h0000, 32'd0, 16'h0000, 4'd1, 1'b0));
        send_command(make_cmd(gcmpt_pkg::CMD_TOGGLE_CH, 16'h0000, 32'd0, 16'h0000, 4'd2, 1'b1));
        send_command(make_cmd(gcmpt_pkg::CMD_WRITE_CH, 16'h0000, 32'd0, 16'h0000, 4'd4, 1'b1));
        send_command(make_cmd(gcmpt_pkg::CMD_TOGGLE_CH, 16'h0000, 32'd0, 16'h0000, 4'd15, 1'b0));
        send_command(make_cmd(gcmpt_pkg::CMD_QUERY_CH, 16'h0000, 32'd0, 16'h0000, 4'd5, 1'b0));
        send_command(make_cmd(CMD_RSVD_6, 16'h1234, 32'd9, 16'h5678, 4'd3, 1'b1));
    endtask

    // every input on pin 15, every output on pin 0, counts above sixteen
    task automatic test_count_limits();
        apply_setting(64'hFFFF_FFFF_FFFF_FFFF, 64'd17, 64'd0, 64'd31);
        send_command(make_cmd(gcmpt_pkg::CMD_SAMPLE, 16'h0000, 32'd7, 16'h0000, 4'd0, 1'b0));
        send_command(make_cmd(gcmpt_pkg::CMD_QUERY_CH, 16'h0000, 32'd8, 16'h0000, 4'd15, 1'b0));
        send_command(make_cmd(gcmpt_pkg::CMD_WRITE_ALL, 16'h0000, 32'd9, 16'h8000, 4'd0, 1'b0));
        send_command(make_cmd(gcmpt_pkg::CMD_WRITE_CH, 16'h0000, 32'd10, 16'h0000, 4'd15, 1'b0));
    endtask

    // random maps and counts, upper bits of the count words set at random
    task automatic test_random_settings();
        logic [63:0] in_cnt;
        logic [63:0] out_cnt;
        int unsigned k;
        int unsigned n;
        for (k = 0; k < 5; k++) begin
            in_cnt = ($urandom_range(3) == 0) ? 64'($urandom_range(31)) :
                                                64'($urandom_range(16, 8));
            out_cnt = ($urandom_range(3) == 0) ? 64'($urandom_range(31)) :
                                                 64'($urandom_range(6));
            if (k == 0) begin
                in_cnt = '0;
                out_cnt = '0;
            end
            in_cnt |= {$urandom, $urandom} & ~64'h1F;
            out_cnt |= {$urandom, $urandom} & ~64'h1F;
            apply_setting({$urandom, $urandom}, in_cnt, {$urandom, $urandom}, out_cnt);
            for (n = 0; n < 65; n++) send_command(random_command());
        end
    endtask

    // receiver holds off so the block fills up; sender then waits for all status
    task automatic test_backpressure();
        int unsigned n;
        sink_hold_req = HOLD_OFF;
        for (n = 0; n < 40; n++) send_command(random_command());
        drain_status();
    endtask

    // back to back traffic on both sides
    task automatic test_no_idle();
        int unsigned n;
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        for (n = 0; n < 50; n++) send_command(random_command());
        drain_status();
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    function automatic string status_text(t_status s);
        return $sformatf({"drive %h dir %h inputs %h changed %b state %0d dur %h ",
                          "lvl %b err %b pad %h"},
                         s.drive, s.dir, s.packed_in, s.changed, s.st, s.dur, s.lev, s.err,
                         s.pad);
    endfunction

    // receiver ready, with random idles and a long hold-off on request
    initial begin : sink_side
        int unsigned hold;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req != 0) begin
                hold = sink_hold_req;
                sink_hold_req = 0;
                i_m_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end else begin
                i_m_tready <= !(sink_idle_en && $urandom_range(99) < 6);
            end
        end
    end

    // compare each status transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen_status = o_m_tdata;
            if (pending_status.size() == 0) begin
                status_mismatches++;
                if (status_mismatches <= 10)
                    $display("status transaction with none pending: %s", status_text(seen_status));
            end else begin
                due_status = pending_status.pop_front();
                statuses_checked++;
                if (seen_status.drive !== due_status.drive || seen_status.dir !== due_status.dir
                    || seen_status.packed_in !== due_status.packed_in
                    || seen_status.changed !== due_status.changed
                    || seen_status.st !== due_status.st || seen_status.dur !== due_status.dur
                    || seen_status.lev !== due_status.lev || seen_status.err !== due_status.err
                    || seen_status.pad !== due_status.pad) begin
                    status_mismatches++;
                    if (status_mismatches <= 10)
                        $display("status %0d mismatch\n  expected %s\n  actual   %s",
                                 statuses_checked, status_text(due_status),
                                 status_text(seen_status));
                end
            end
        end
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (psel && penable && pwrite && pready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        shadow_reset();
        tick_now = $urandom;
        pin_pattern = gcmpt_pkg::PORT_W'($urandom);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed_mapping();
        test_count_limits();
        test_random_settings();
        test_backpressure();
        test_no_idle();
        drain_status();
        $display("%0d commands (samples, latch writes, toggles, queries, unknown codes)",
                 items_sent);
        $display("%0d status checked over %0d register writes, with hold-off and idle-free runs",
                 statuses_checked, reg_writes);
        if (status_mismatches == 0 && pending_status.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
